// ===== hdl/skh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skh_pkg
// shared types and codes for the sorted key histogram
// ----------------------------------------------------------------------------
package skh_pkg;

   localparam int NAME_W  = 64;
   localparam int FRAME_W = 64;
   localparam int ID_W    = 31;
   localparam int CNT_W   = 32;
   localparam int POS_W   = 10;
   localparam int USED_W  = 11;
   localparam int FRAMES  = 4;

   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_BAD_IDX  = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   // one table entry: key fields and count
   typedef struct packed {
      logic [FRAMES-1:0][FRAME_W-1:0] frames;
      logic [ID_W-1:0]                pid;
      logic [ID_W-1:0]                tid;
      logic [NAME_W-1:0]              head;
      logic [NAME_W-1:0]              tail;
      logic [CNT_W-1:0]               tally;
   } entry_type;

   // sequencer to datapath
   typedef struct packed {
      logic load_key;    // capture request key
      logic rd_en;       // read table at rd_addr
      logic probe;       // read probe address
      logic shift_rd;    // read entry below shift pointer
      logic shift_wr;    // write previously read entry one up
      logic ins_wr;      // write new key at insert point
      logic hit_wr;      // write incremented tally at probe
      logic clear;       // empty the table
      logic read_op;     // read entry at request index
      logic step_cmp;    // narrow the search window
      logic emit;        // load response register
      status_type status;
   } dp_cmd_type;

   // datapath to sequencer
   typedef struct packed {
      logic done_search; // window closed
      logic cmp_eq;      // probed entry equals key
      logic full;        // table holds the maximum
      logic shift_done;  // shift pointer reached insert point
      logic idx_ok;      // read index in range
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== hdl/skh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skh_datapath
// table memory, key compare, search window, shift pointer and response regs
// ----------------------------------------------------------------------------
module skh_datapath #(
   parameter int ENTRIES     = 1024,
   parameter int TRACE_DEPTH = 4,
   parameter int NAME_BYTES  = 16,
   parameter int AW          = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          key_mode,
   input  wire skh_pkg::dp_cmd_type     cmd,
   output skh_pkg::dp_sts_type          sts,
   input  wire [skh_pkg::POS_W-1:0]     req_read_index,
   input  wire [skh_pkg::ID_W-1:0]      req_proc_id,
   input  wire [skh_pkg::ID_W-1:0]      req_thread_id,
   input  wire [skh_pkg::NAME_W-1:0]    req_name_head,
   input  wire [skh_pkg::NAME_W-1:0]    req_name_tail,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_0,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_1,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_2,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_3,
   output logic [2:0]                   rsp_status,
   output logic [skh_pkg::POS_W-1:0]    rsp_position,
   output logic [skh_pkg::CNT_W-1:0]    rsp_hit_count,
   output logic [skh_pkg::USED_W-1:0]   rsp_entries_used,
   output logic [skh_pkg::ID_W-1:0]     rsp_out_proc_id,
   output logic [skh_pkg::ID_W-1:0]     rsp_out_thread_id,
   output logic [skh_pkg::NAME_W-1:0]   rsp_out_name_head,
   output logic [skh_pkg::NAME_W-1:0]   rsp_out_name_tail,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_0,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_1,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_2,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_3
);
   import skh_pkg::*;

   localparam int UW = AW + 1;

   entry_type mem [ENTRIES];
   entry_type rdata_ff;
   entry_type key_ff, key_in;

   logic [UW-1:0] used_ff, used_in;
   logic [UW:0]   lo_ff, lo_in, hi_ff, hi_in;  // signed window bounds
   logic [UW:0]   pos_w;
   logic [UW-1:0] ptr_ff, ptr_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   entry_type     wr_data;
   logic          gt_w, eq_w;

   // name masking: zero bytes after first zero and beyond NAME_BYTES
   logic [2*NAME_W-1:0] name_raw, name_clean;
   always_comb begin
      logic ended;
      ended = 1'b0;
      name_raw = {req_name_head, req_name_tail};
      name_clean = '0;
      for (int i = 0; i < 16; i++) begin
         if (i < NAME_BYTES && !ended) begin
            name_clean[127-8*i -: 8] = name_raw[127-8*i -: 8];
            if (name_raw[127-8*i -: 8] == 8'd0) ended = 1'b1;
         end
      end
   end

   always_comb begin
      key_in = key_ff;
      if (cmd.load_key) begin
         key_in.pid   = req_proc_id;
         key_in.tid   = req_thread_id;
         key_in.head  = name_clean[127:64];
         key_in.tail  = name_clean[63:0];
         key_in.tally = CNT_W'(1);
         key_in.frames[0] = (key_mode && TRACE_DEPTH > 0) ? req_frame_0 : '0;
         key_in.frames[1] = (key_mode && TRACE_DEPTH > 1) ? req_frame_1 : '0;
         key_in.frames[2] = (key_mode && TRACE_DEPTH > 2) ? req_frame_2 : '0;
         key_in.frames[3] = (key_mode && TRACE_DEPTH > 3) ? req_frame_3 : '0;
      end
   end

   // key compare against registered read data; frames are zero in user mode
   logic [FRAMES*FRAME_W+2*ID_W+2*NAME_W-1:0] ka, kb, fb;
   always_comb begin
      fb = '0;
      for (int i = 0; i < FRAMES; i++)
         if (key_mode && i < TRACE_DEPTH)
            fb[FRAMES*FRAME_W+2*ID_W+2*NAME_W-1-FRAME_W*i -: FRAME_W] = rdata_ff.frames[i];
      ka = {key_ff.frames[0], key_ff.frames[1], key_ff.frames[2], key_ff.frames[3],
            key_ff.pid, key_ff.tid, key_ff.head, key_ff.tail};
      kb = {fb[FRAMES*FRAME_W+2*ID_W+2*NAME_W-1 -: FRAMES*FRAME_W],
            rdata_ff.pid, rdata_ff.tid, rdata_ff.head, rdata_ff.tail};
      gt_w = ka > kb;
      eq_w = ka == kb;
   end

   assign pos_w = lo_ff + ((hi_ff - lo_ff + (UW+1)'(1)) >> 1);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      rd_addr = pos_w[AW-1:0];
      wr_addr = pos_w[AW-1:0];
      wr_en = 1'b0;
      wr_data = rdata_ff;
      if (cmd.load_key) begin
         lo_in = '1;
         hi_in = {1'b0, used_ff};
         ptr_in = used_ff;
      end
      if (cmd.step_cmp) begin
         if (gt_w) lo_in = pos_w;
         else hi_in = pos_w;
      end
      if (cmd.read_op) rd_addr = req_read_index[AW-1:0];
      if (cmd.read_op && cmd.rd_en) idx_in = req_read_index;
      if (cmd.shift_rd) begin
         rd_addr = AW'(ptr_ff - UW'(1));
      end
      if (cmd.shift_wr) begin
         wr_en = 1'b1;
         wr_addr = ptr_ff[AW-1:0];
         wr_data = rdata_ff;
         ptr_in = ptr_ff - UW'(1);
      end
      if (cmd.ins_wr) begin
         wr_en = 1'b1;
         wr_addr = pos_w[AW-1:0];
         wr_data = key_ff;
         used_in = used_ff + UW'(1);
      end
      if (cmd.hit_wr) begin
         wr_en = 1'b1;
         wr_data = rdata_ff;
         if (rdata_ff.tally != '1) wr_data.tally = rdata_ff.tally + CNT_W'(1);
      end
      if (cmd.clear) used_in = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      key_ff <= key_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      idx_ff <= idx_in;
   end

   assign sts.done_search = (pos_w == hi_ff);
   assign sts.cmp_eq      = eq_w;
   assign sts.full        = (used_ff == UW'(ENTRIES));
   assign sts.shift_done  = (ptr_ff == pos_w[UW-1:0]);
   assign sts.idx_ok      = ({1'b0, idx_ff} < (POS_W+1)'(used_ff)) &&
                            (32'(idx_ff) < ENTRIES);

   // response: entry source is key (insert), updated entry (hit) or read data
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         entry_type e;
         logic show;
         e = rdata_ff;
         if (cmd.status == ST_INSERTED) e = key_ff;
         if (cmd.status == ST_HIT && !cmd.read_op && rdata_ff.tally != '1)
            e.tally = rdata_ff.tally + CNT_W'(1);
         show = (cmd.status == ST_HIT) || (cmd.status == ST_INSERTED);
         rsp_status       <= cmd.status;
         rsp_entries_used <= USED_W'(used_in);
         rsp_position     <= show ? (cmd.read_op ? idx_ff : POS_W'(pos_w)) : '0;
         rsp_hit_count    <= show ? e.tally : '0;
         rsp_out_proc_id  <= show ? e.pid : '0;
         rsp_out_thread_id<= show ? e.tid : '0;
         rsp_out_name_head<= show ? e.head : '0;
         rsp_out_name_tail<= show ? e.tail : '0;
         rsp_out_frame_0  <= (show && key_mode && TRACE_DEPTH > 0) ? e.frames[0] : '0;
         rsp_out_frame_1  <= (show && key_mode && TRACE_DEPTH > 1) ? e.frames[1] : '0;
         rsp_out_frame_2  <= (show && key_mode && TRACE_DEPTH > 2) ? e.frames[2] : '0;
         rsp_out_frame_3  <= (show && key_mode && TRACE_DEPTH > 3) ? e.frames[3] : '0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/skh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skh_ctrl
// sequencer for search, hit update, shift-insert, read and clear
// ----------------------------------------------------------------------------
module skh_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire [1:0]                req_operation,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output skh_pkg::dp_cmd_type      cmd,
   input  wire skh_pkg::dp_sts_type sts
);
   import skh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_PROBE, S_WAIT, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_INSERT,
      S_READ, S_READ_EMIT, S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.status = ST_HIT;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_COUNT: cmd.load_key = 1'b1;
                  OP_READ: begin
                     cmd.read_op = 1'b1;
                     cmd.rd_en = 1'b1;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     cmd.emit = 1'b1;
                     cmd.status = ST_CLEARED;
                  end
                  default: ;
               endcase
            end
         end
         S_PROBE: begin
            if (sts.done_search) begin
               if (sts.full) begin
                  cmd.emit = 1'b1;
                  cmd.status = ST_FULL;
               end
            end else begin
               cmd.rd_en = 1'b1;
               cmd.probe = 1'b1;
            end
         end
         S_CMP: begin
            if (sts.cmp_eq) begin
               cmd.hit_wr = 1'b1;
               cmd.emit = 1'b1;
               cmd.status = ST_HIT;
            end else begin
               cmd.step_cmp = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            if (!sts.shift_done) begin
               cmd.rd_en = 1'b1;
               cmd.shift_rd = 1'b1;
            end
         end
         S_SHIFT_WR: cmd.shift_wr = 1'b1;
         S_INSERT: begin
            cmd.ins_wr = 1'b1;
            cmd.emit = 1'b1;
            cmd.status = ST_INSERTED;
         end
         S_READ_EMIT: begin
            cmd.read_op = 1'b1;
            cmd.emit = 1'b1;
            cmd.status = sts.idx_ok ? ST_HIT : ST_BAD_IDX;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  case (op_type'(req_operation))
                     OP_COUNT: state_ff <= S_PROBE;
                     OP_READ:  state_ff <= S_READ;
                     OP_CLEAR: state_ff <= S_OUT;
                     default:  state_ff <= S_IDLE;
                  endcase
               end
            end
            S_PROBE: begin
               if (sts.done_search) state_ff <= sts.full ? S_OUT : S_SHIFT_RD;
               else state_ff <= S_WAIT;
            end
            S_WAIT: state_ff <= S_CMP;
            S_CMP: state_ff <= sts.cmp_eq ? S_OUT : S_PROBE;
            S_SHIFT_RD: state_ff <= sts.shift_done ? S_INSERT : S_SHIFT_WR;
            S_SHIFT_WR: state_ff <= S_SHIFT_RD;
            S_INSERT: state_ff <= S_OUT;
            S_READ: state_ff <= S_READ_EMIT;
            S_READ_EMIT: state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sorted_key_histogram_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_histogram_core
// sorted key table with saturating occurrence counts
// ----------------------------------------------------------------------------
// usage: req_ channel carries one transaction per operation (count, read,
// clear); rsp_ channel returns exactly one transaction for each, none for
// operation code 3. user writes key_mode via csr_ only while idle (unchecked).
// sequence: a count makes binary search probes (at most floor(log2(used))+1),
// each reading the probed entry, waiting, then comparing; a hit writes the
// incremented tally back; a miss, unless the table is full, moves entries up
// one at a time, each read then written, then inserts the key.
// one transaction at a time; req_stall is high from acceptance until the
// response has been taken.
// reset empties the table and sets key_mode to user keys; no clearing pass.
// while rsp_stall is high the response holds and no new request is taken.
// ----------------------------------------------------------------------------
module sorted_key_histogram_core #(
   parameter int ENTRIES     = 1024,
   parameter int TRACE_DEPTH = 4,
   parameter int NAME_BYTES  = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_write_enable,
   input  wire                          csr_write_data,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [1:0]                    req_operation,
   input  wire [skh_pkg::POS_W-1:0]     req_read_index,
   input  wire [skh_pkg::ID_W-1:0]      req_proc_id,
   input  wire [skh_pkg::ID_W-1:0]      req_thread_id,
   input  wire [skh_pkg::NAME_W-1:0]    req_name_head,
   input  wire [skh_pkg::NAME_W-1:0]    req_name_tail,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_0,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_1,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_2,
   input  wire [skh_pkg::FRAME_W-1:0]   req_frame_3,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [skh_pkg::POS_W-1:0]    rsp_position,
   output logic [skh_pkg::CNT_W-1:0]    rsp_hit_count,
   output logic [skh_pkg::USED_W-1:0]   rsp_entries_used,
   output logic [skh_pkg::ID_W-1:0]     rsp_out_proc_id,
   output logic [skh_pkg::ID_W-1:0]     rsp_out_thread_id,
   output logic [skh_pkg::NAME_W-1:0]   rsp_out_name_head,
   output logic [skh_pkg::NAME_W-1:0]   rsp_out_name_tail,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_0,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_1,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_2,
   output logic [skh_pkg::FRAME_W-1:0]  rsp_out_frame_3
);
   import skh_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   logic       key_mode_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         key_mode_ff <= csr_write_data;
      end
   end

   skh_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   skh_datapath #(
      .ENTRIES(ENTRIES), .TRACE_DEPTH(TRACE_DEPTH), .NAME_BYTES(NAME_BYTES), .AW(AW)
   ) u_dp (
      .clock(clock), .reset(reset), .key_mode(key_mode_ff), .cmd(cmd), .sts(sts),
      .req_read_index(req_read_index), .req_proc_id(req_proc_id),
      .req_thread_id(req_thread_id), .req_name_head(req_name_head),
      .req_name_tail(req_name_tail), .req_frame_0(req_frame_0),
      .req_frame_1(req_frame_1), .req_frame_2(req_frame_2), .req_frame_3(req_frame_3),
      .rsp_status(rsp_status), .rsp_position(rsp_position),
      .rsp_hit_count(rsp_hit_count), .rsp_entries_used(rsp_entries_used),
      .rsp_out_proc_id(rsp_out_proc_id), .rsp_out_thread_id(rsp_out_thread_id),
      .rsp_out_name_head(rsp_out_name_head), .rsp_out_name_tail(rsp_out_name_tail),
      .rsp_out_frame_0(rsp_out_frame_0), .rsp_out_frame_1(rsp_out_frame_1),
      .rsp_out_frame_2(rsp_out_frame_2), .rsp_out_frame_3(rsp_out_frame_3)
   );

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with response pending");
   a_emit_idle_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid) else $error("response not raised");
   a_full_no_insert: assert property (@(posedge clock) disable iff (reset)
      (cmd.ins_wr && sts.full) |-> 1'b0) else $error("insert into full table");
`endif

endmodule

`default_nettype wire
